/* sv/clns_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_pkg
// Shared types, constants and the control store of the LCD nibble sequencer.
// ---------------------------------------------------------------------------
package clns_pkg;

   localparam int LINE_WIDTH_DEFAULT = 16;
   localparam int COLUMN_WIDTH       = 5;
   localparam int PC_WIDTH           = 5;

   localparam logic [7:0] PAD_CHAR_RESET = 8'h20;
   localparam logic [7:0] CMD_LINE0      = 8'h80;
   localparam logic [7:0] CMD_LINE1      = 8'hC0;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
   localparam logic [7:0] WAKE_8BIT      = 8'h03;
   localparam logic [7:0] WAKE_4BIT      = 8'h02;

   // register indexes
   localparam logic REG_PAD_CHAR = 1'b0;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_SELECT = 2'd1,
      OP_PUT    = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SRC_IMM  = 2'd0,
      SRC_LINE = 2'd1,
      SRC_CHAR = 2'd2,
      SRC_PAD  = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      COL_KEEP  = 2'd0,
      COL_CLEAR = 2'd1,
      COL_INCR  = 2'd2
   } col_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT      = 2'd0,
      SEQ_DONE      = 2'd1,
      SEQ_SKIP_FULL = 2'd2,
      SEQ_LOOP_ROOM = 2'd3
   } seq_type;

   typedef struct packed {
      logic                emit;
      src_type             src;
      logic                hi;
      logic                rs;
      logic                last;
      logic                last_at_end;
      col_op_type          col_op;
      seq_type             seq;
      logic [PC_WIDTH-1:0] target;
      logic [7:0]          imm;
   } ucode_word_type;

   typedef struct packed {
      logic           fire;
      ucode_word_type word;
   } step_ctrl_type;

   typedef struct packed {
      logic full;
      logic room;
      logic load_ok;
   } dp_status_type;

   // program entry points
   localparam logic [PC_WIDTH-1:0] ENTRY_INIT   = 5'd0;
   localparam logic [PC_WIDTH-1:0] ENTRY_SELECT = 5'd14;
   localparam logic [PC_WIDTH-1:0] ENTRY_PUT    = 5'd16;
   localparam logic [PC_WIDTH-1:0] ENTRY_FINISH = 5'd19;
   localparam logic [PC_WIDTH-1:0] PAD_LOOP     = 5'd20;

   function automatic ucode_word_type uw(input logic emit, input src_type src, input logic hi,
                                         input logic rs, input logic last,
                                         input logic last_at_end, input col_op_type col_op,
                                         input seq_type seq, input logic [PC_WIDTH-1:0] target,
                                         input logic [7:0] imm);
      ucode_word_type w;
      w.emit        = emit;
      w.src         = src;
      w.hi          = hi;
      w.rs          = rs;
      w.last        = last;
      w.last_at_end = last_at_end;
      w.col_op      = col_op;
      w.seq         = seq;
      w.target      = target;
      w.imm         = imm;
      return w;
   endfunction

   // control store: one nibble (or one test) per step
   function automatic ucode_word_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_word_type w;
      w = uw(1'b0, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_DONE, '0, '0);
      case (pc)
         5'd0:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, WAKE_8BIT);
         5'd1:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, WAKE_8BIT);
         5'd2:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, WAKE_8BIT);
         5'd3:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, WAKE_4BIT);
         5'd4:  w = uw(1'b1, SRC_IMM, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_FUNC_SET);
         5'd5:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_FUNC_SET);
         5'd6:  w = uw(1'b1, SRC_IMM, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_DISP_OFF);
         5'd7:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_DISP_OFF);
         5'd8:  w = uw(1'b1, SRC_IMM, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, CMD_CLEAR);
         5'd9:  w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, CMD_CLEAR);
         5'd10: w = uw(1'b1, SRC_IMM, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_ENTRY_MODE);
         5'd11: w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_ENTRY_MODE);
         5'd12: w = uw(1'b1, SRC_IMM, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0,
                       CMD_DISP_ON);
         5'd13: w = uw(1'b1, SRC_IMM, 1'b0, 1'b0, 1'b1, 1'b0, COL_CLEAR, SEQ_DONE, '0,
                       CMD_DISP_ON);
         5'd14: w = uw(1'b1, SRC_LINE, 1'b1, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, '0);
         5'd15: w = uw(1'b1, SRC_LINE, 1'b0, 1'b0, 1'b1, 1'b0, COL_CLEAR, SEQ_DONE, '0, '0);
         5'd16: w = uw(1'b0, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_SKIP_FULL, '0, '0);
         5'd17: w = uw(1'b1, SRC_CHAR, 1'b1, 1'b1, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, '0);
         5'd18: w = uw(1'b1, SRC_CHAR, 1'b0, 1'b1, 1'b1, 1'b0, COL_INCR, SEQ_DONE, '0, '0);
         5'd19: w = uw(1'b0, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_SKIP_FULL, '0, '0);
         5'd20: w = uw(1'b1, SRC_PAD, 1'b1, 1'b1, 1'b0, 1'b0, COL_KEEP, SEQ_NEXT, '0, '0);
         5'd21: w = uw(1'b1, SRC_PAD, 1'b0, 1'b1, 1'b0, 1'b1, COL_INCR, SEQ_LOOP_ROOM,
                       PAD_LOOP, '0);
         default: w = uw(1'b0, SRC_IMM, 1'b0, 1'b0, 1'b0, 1'b0, COL_KEEP, SEQ_DONE, '0, '0);
      endcase
      return w;
   endfunction

endpackage

/* sv/clns_sequencer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_sequencer
// Step counter and control store: dispatches on the op and walks the program.
// ---------------------------------------------------------------------------
module clns_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  clns_pkg::op_type               op,
   input  clns_pkg::dp_status_type        status,
   output logic                           busy,
   output clns_pkg::step_ctrl_type        ctrl
);

   logic                          busy_ff, busy_in;
   logic [clns_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   clns_pkg::ucode_word_type      word;
   logic                          fire;

   assign word = clns_pkg::ucode_rom(pc_ff);
   // a step waits only if it emits and the output register is still held
   assign fire = busy_ff && (!word.emit || status.load_ok);

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            case (op)
               clns_pkg::OP_INIT:   pc_in = clns_pkg::ENTRY_INIT;
               clns_pkg::OP_SELECT: pc_in = clns_pkg::ENTRY_SELECT;
               clns_pkg::OP_PUT:    pc_in = clns_pkg::ENTRY_PUT;
               clns_pkg::OP_FINISH: pc_in = clns_pkg::ENTRY_FINISH;
               default:             pc_in = clns_pkg::ENTRY_INIT;
            endcase
         end
      end else if (fire) begin
         case (word.seq)
            clns_pkg::SEQ_NEXT: pc_in = pc_ff + 1'b1;
            clns_pkg::SEQ_DONE: busy_in = 1'b0;
            clns_pkg::SEQ_SKIP_FULL: begin
               if (status.full) busy_in = 1'b0;
               else pc_in = pc_ff + 1'b1;
            end
            clns_pkg::SEQ_LOOP_ROOM: begin
               if (status.room) pc_in = word.target;
               else busy_in = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy      = busy_ff;
   assign ctrl.fire = fire;
   assign ctrl.word = word;

endmodule

/* sv/clns_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clns_datapath
// Column counter, operand latch, nibble select and output register.
// ---------------------------------------------------------------------------
module clns_datapath #(
   parameter int LINE_WIDTH = clns_pkg::LINE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     line_select,
   input  logic [7:0]               char_code,
   input  logic [7:0]               pad_char,
   input  clns_pkg::step_ctrl_type  ctrl,
   output clns_pkg::dp_status_type  status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_nibble,
   output logic                     rsp_rs,
   output logic                     rsp_last
);

   localparam logic [clns_pkg::COLUMN_WIDTH-1:0] WidthVal = clns_pkg::COLUMN_WIDTH'(LINE_WIDTH);

   logic [clns_pkg::COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [clns_pkg::COLUMN_WIDTH-1:0] column_inc;
   logic                              line_ff;
   logic [7:0]                        char_ff;
   logic                              valid_ff, valid_in;
   logic [3:0]                        nibble_ff;
   logic                              rs_ff, last_ff;
   logic [7:0]                        src_byte;
   logic [3:0]                        nib;
   logic                              at_end, load;

   assign column_inc     = column_ff + 1'b1;
   assign at_end         = column_inc >= WidthVal;
   assign status.full    = column_ff >= WidthVal;
   assign status.room    = !at_end;
   assign status.load_ok = !valid_ff || rsp_ready;

   always_comb begin
      case (ctrl.word.src)
         clns_pkg::SRC_IMM:  src_byte = ctrl.word.imm;
         clns_pkg::SRC_LINE: src_byte = line_ff ? clns_pkg::CMD_LINE1 : clns_pkg::CMD_LINE0;
         clns_pkg::SRC_CHAR: src_byte = char_ff;
         clns_pkg::SRC_PAD:  src_byte = pad_char;
         default:            src_byte = ctrl.word.imm;
      endcase
   end

   assign nib  = ctrl.word.hi ? src_byte[7:4] : src_byte[3:0];
   assign load = ctrl.fire && ctrl.word.emit;

   always_comb begin
      column_in = column_ff;
      if (ctrl.fire) begin
         case (ctrl.word.col_op)
            clns_pkg::COL_CLEAR: column_in = '0;
            clns_pkg::COL_INCR:  column_in = column_inc;
            default:             column_in = column_ff;
         endcase
      end
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         column_ff <= column_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         line_ff <= line_select;
         char_ff <= char_code;
      end
      if (load) begin
         nibble_ff <= nib;
         rs_ff     <= ctrl.word.rs;
         last_ff   <= ctrl.word.last || (ctrl.word.last_at_end && at_end);
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_nibble = nibble_ff;
   assign rsp_rs     = rs_ff;
   assign rsp_last   = last_ff;

endmodule

/* sv/char_lcd_nibble_sequencer_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Host side of a 4-bit character LCD: turns init, select-line, put-char and
// finish-line transactions into a stream of RS-tagged nibbles.
// ---------------------------------------------------------------------------
// One transaction is taken per program run. The accept cycle dispatches, then
// a microcoded sequencer runs one control word per cycle, each word emitting
// at most one nibble. Put-char is dropped when the line is full, and
// finish-line pads every remaining column with the pad character.
// A new request is taken the cycle after the program ends; the output register
// lets the last nibble wait while the next request is accepted. Back-pressure
// on the result side holds the sequencer on its current step.
module char_lcd_nibble_sequencer_core #(
   parameter int LINE_WIDTH = clns_pkg::LINE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] line_select, [8:1] char_code, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] nibble, rest zero
   output logic        rsp_tuser,   // [0] reg_select
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                      busy, start;
   logic [7:0]                pad_char_ff, pad_char_in;
   logic                      csr_write;
   logic [3:0]                nibble;
   clns_pkg::step_ctrl_type   ctrl;
   clns_pkg::dp_status_type   status;

   assign req_tready = !busy;
   assign start      = req_tvalid && !busy;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == clns_pkg::REG_PAD_CHAR);
   assign csr_prdata = (csr_paddr[2] == clns_pkg::REG_PAD_CHAR) ? {24'd0, pad_char_ff} : 32'd0;
   assign pad_char_in = csr_write ? csr_pwdata[7:0] : pad_char_ff;

   always_ff @(posedge clock) begin
      if (reset) pad_char_ff <= clns_pkg::PAD_CHAR_RESET;
      else pad_char_ff <= pad_char_in;
   end

   clns_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (clns_pkg::op_type'(req_tuser)),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   clns_datapath #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .line_select (req_tdata[0]),
      .char_code   (req_tdata[8:1]),
      .pad_char    (pad_char_ff),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_nibble  (nibble),
      .rsp_rs      (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, nibble};

endmodule
